// ===== src/ksu_pkg.sv =====
// ----------------------------------------------------------------------------
// ksu_pkg
// Shared types and constants for the canonical k-mer sketch update block.
// ----------------------------------------------------------------------------
package ksu_pkg;

    localparam int INDEX_BITS = 12;
    localparam int KMER_BASES = 32;
    localparam int MAX_LEVEL  = 62;

    localparam int NUM_REGS   = 1 << INDEX_BITS;
    localparam int REST_BITS  = 64 - INDEX_BITS;
    localparam int THR_DEPTH  = 63;
    localparam int RUN_BITS   = $clog2(KMER_BASES + 1);

    localparam logic [63:0] FMIX_C1   = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2   = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] HASH_SEED = 64'd42;

    localparam logic [1:0] OP_CHAR  = 2'd0;
    localparam logic [1:0] OP_THR   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  base_char;
        logic        first_of_sequence;
        logic [5:0]  threshold_index;
        logic [60:0] threshold_value;
        logic [11:0] register_select;
    } t_in_item;

    typedef struct packed {
        logic        kmer_valid;
        logic [63:0] kmer_hash;
        logic [11:0] register_index;
        logic        register_updated;
        logic [5:0]  register_value;
        logic [63:0] witness_value;
    } t_out_item;

endpackage

// ===== src/ksu_mul32.sv =====
// ----------------------------------------------------------------------------
// ksu_mul32
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ksu_mul32 (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== src/ksu_window.sv =====
// ----------------------------------------------------------------------------
// ksu_window
// Forward and reverse-complement 2-bit base windows with a valid-run count.
// ----------------------------------------------------------------------------
module ksu_window (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic        i_first,
    input  logic [7:0]  i_char,
    output logic [63:0] o_fwd,
    output logic [63:0] o_rev,
    output logic        o_full
);

    logic [63:0] r_fwd, n_fwd;
    logic [63:0] r_rev, n_rev;
    logic [ksu_pkg::RUN_BITS-1:0] r_run, n_run;
    logic [63:0] fwd_base, rev_base;
    logic [ksu_pkg::RUN_BITS-1:0] run_base;
    logic [1:0]  code;
    logic        code_ok;

    always_comb begin
        code    = 2'd0;
        code_ok = 1'b1;
        case (i_char)
            8'h41, 8'h61: code = 2'd0;
            8'h43, 8'h63: code = 2'd1;
            8'h47, 8'h67: code = 2'd2;
            8'h54, 8'h74: code = 2'd3;
            default:      code_ok = 1'b0;
        endcase
    end

    always_comb begin
        fwd_base = i_first ? 64'd0 : r_fwd;
        rev_base = i_first ? 64'd0 : r_rev;
        run_base = i_first ? '0 : r_run;
        if (code_ok) begin
            n_fwd = {fwd_base[61:0], code};
            n_rev = {~code, rev_base[63:2]};
            n_run = (run_base < ksu_pkg::RUN_BITS'(ksu_pkg::KMER_BASES))
                    ? run_base + 1'b1 : run_base;
        end else begin
            n_fwd = {fwd_base[61:0], 2'b00};
            n_rev = {2'b00, rev_base[63:2]};
            n_run = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= '0;
            r_rev <= '0;
            r_run <= '0;
        end else if (i_load) begin
            r_fwd <= n_fwd;
            r_rev <= n_rev;
            r_run <= n_run;
        end
    end

    assign o_fwd  = r_fwd;
    assign o_rev  = r_rev;
    assign o_full = (r_run >= ksu_pkg::RUN_BITS'(ksu_pkg::KMER_BASES));

endmodule

// ===== src/kmer_setsketch_update.sv =====
// ----------------------------------------------------------------------------
// kmer_setsketch_update
// Canonical 32-mer hashing (fmix64) into a 4096-register SetSketch with
// witnesses, host-loaded level thresholds and register reads.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake             | Payload
// in      | input     | i_in_valid/o_in_stall | t_in_item
// out     | output    | o_out_valid/i_out_stall | t_out_item
//
// A threshold write goes straight to the finish state, a register read
// through a read wait and read state, a non-completing character through
// the window state. A completed k-mer runs two multiply/mix passes, a level
// read and a threshold read and compare per level compared; each 64-bit
// multiply runs as three partial products on one 32x32 unit. After reset a
// clearing pass over all 4096 registers zeroes them and their witnesses,
// with input stalled. New input is taken while a result waits for output.
// ----------------------------------------------------------------------------
module kmer_setsketch_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ksu_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ksu_pkg::t_out_item o_out_item
);

    localparam int IB = ksu_pkg::INDEX_BITS;
    localparam int RB = ksu_pkg::REST_BITS;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_WIN   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_MIX   = 4'd4;
    localparam logic [3:0] S_LVRD  = 4'd5;
    localparam logic [3:0] S_LV    = 4'd6;
    localparam logic [3:0] S_TWAIT = 4'd7;
    localparam logic [3:0] S_CMP   = 4'd8;
    localparam logic [3:0] S_UPD   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_RDW   = 4'd11;
    localparam logic [3:0] S_RD    = 4'd12;

    logic [3:0]    r_state;
    logic [IB:0]   r_clr;
    logic [1:0]    r_step;
    logic          r_pass;
    logic [63:0]   r_acc;
    logic [63:0]   r_h;
    logic [IB-1:0] r_addr;
    logic [5:0]    r_k;
    logic [5:0]    r_cur;
    logic          r_hit;
    ksu_pkg::t_out_item r_res;
    ksu_pkg::t_out_item r_out;
    logic          r_out_valid;

    logic          accept;
    logic          out_free;
    logic [63:0]   fwd, rev, canon, xkey;
    logic          win_full;
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_p;
    logic [63:0]   mconst;
    logic          reach;
    logic [RB-1:0] rest;

    // sketch storage
    logic [5:0]    lv_mem  [ksu_pkg::NUM_REGS];
    logic [63:0]   wit_mem [ksu_pkg::NUM_REGS];
    logic [60:0]   thr_mem [ksu_pkg::THR_DEPTH];
    logic [5:0]    r_lv_q;
    logic [63:0]   r_wit_q;
    logic [60:0]   r_thr_q;
    logic          wr_en;
    logic [IB-1:0] wr_addr;
    logic [5:0]    wr_lv;
    logic [63:0]   wr_wit;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    ksu_window u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && i_in_item.operation == ksu_pkg::OP_CHAR),
        .i_first (i_in_item.first_of_sequence),
        .i_char  (i_in_item.base_char),
        .o_fwd   (fwd),
        .o_rev   (rev),
        .o_full  (win_full)
    );

    assign canon = (fwd <= rev) ? fwd : rev;
    assign xkey  = canon ^ ksu_pkg::HASH_SEED;

    // low*low, high*low, low*high; cross terms land in the upper half
    assign mconst = r_pass ? ksu_pkg::FMIX_C2 : ksu_pkg::FMIX_C1;
    always_comb begin
        case (r_step)
            2'd0:    begin mul_a = r_h[31:0];  mul_b = mconst[31:0];  end
            2'd1:    begin mul_a = r_h[63:32]; mul_b = mconst[31:0];  end
            2'd2:    begin mul_a = r_h[31:0];  mul_b = mconst[63:32]; end
            default: begin mul_a = r_h[31:0];  mul_b = mconst[31:0];  end
        endcase
    end

    ksu_mul32 u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign rest  = r_h[RB-1:0];
    assign reach = (r_k <= 6'(ksu_pkg::MAX_LEVEL)) && (r_k < 6'(ksu_pkg::THR_DEPTH))
                   && (64'(rest) >= 64'(r_thr_q));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_lv   = r_k;
        wr_wit  = r_h;
        if (r_state == S_CLR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr[IB-1:0];
            wr_lv   = '0;
            wr_wit  = '0;
        end else if (r_state == S_UPD && r_hit) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            lv_mem[wr_addr]  <= wr_lv;
            wit_mem[wr_addr] <= wr_wit;
        end
        r_lv_q  <= lv_mem[r_addr];
        r_wit_q <= wit_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_item.operation == ksu_pkg::OP_THR
            && i_in_item.threshold_index < 6'(ksu_pkg::THR_DEPTH)) begin
            thr_mem[i_in_item.threshold_index] <= i_in_item.threshold_value;
        end
        r_thr_q <= thr_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_step      <= '0;
            r_pass      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (IB+1)'(ksu_pkg::NUM_REGS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_res <= '0;
                        r_hit <= 1'b0;
                        case (i_in_item.operation)
                            ksu_pkg::OP_CHAR: r_state <= S_WIN;
                            ksu_pkg::OP_READ: begin
                                r_addr  <= i_in_item.register_select[IB-1:0];
                                r_state <= S_RDW;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_WIN: begin
                    if (win_full) begin
                        r_h     <= xkey ^ (xkey >> 33);
                        r_step  <= '0;
                        r_pass  <= 1'b0;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        2'd0:    r_acc <= r_acc;
                        2'd1:    r_acc <= mul_p;
                        default: r_acc <= r_acc + {mul_p[31:0], 32'd0};
                    endcase
                    if (r_step == 2'd3) begin
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_h    <= r_acc ^ (r_acc >> 33);
                    r_step <= '0;
                    if (!r_pass) begin
                        r_pass  <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_addr  <= IB'((r_acc ^ (r_acc >> 33)) >> RB);
                        r_state <= S_LVRD;
                    end
                end
                S_LVRD: r_state <= S_LV;
                S_LV: begin
                    r_cur   <= r_lv_q;
                    r_k     <= r_lv_q;
                    r_state <= S_TWAIT;
                end
                S_TWAIT: r_state <= S_CMP;
                S_CMP: begin
                    if (reach) begin
                        r_hit <= 1'b1;
                        r_k   <= r_k + 1'b1;
                        if (r_k + 1'b1 < 6'(ksu_pkg::MAX_LEVEL)) begin
                            r_state <= S_TWAIT;
                        end else begin
                            r_state <= S_UPD;
                        end
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_res.kmer_valid       <= 1'b1;
                    r_res.kmer_hash        <= r_h;
                    r_res.register_index   <= 12'(r_addr);
                    r_res.register_updated <= r_hit;
                    r_res.register_value   <= r_hit ? r_k : r_cur;
                    r_res.witness_value    <= r_hit ? r_h : r_wit_q;
                    r_state                <= S_FIN;
                end
                S_RDW: r_state <= S_RD;
                S_RD: begin
                    r_res.register_index <= 12'(r_addr);
                    r_res.register_value <= r_lv_q;
                    r_res.witness_value  <= r_wit_q;
                    r_state              <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== src/ksu_checker.sv =====
// ----------------------------------------------------------------------------
// ksu_checker
// Port-level checks for the sketch update block, bound to the top level.
// ----------------------------------------------------------------------------
module ksu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ksu_pkg::t_out_item o_out_item
);

    // held result must not change under stall
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output changed while stalled");

    // one transaction at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    a_upd_kmer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.register_updated |->
            o_out_item.kmer_valid && o_out_item.register_value != 6'd0)
        else $error("update without k-mer");

    a_nokmer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.kmer_valid |->
            o_out_item.kmer_hash == 64'd0 && !o_out_item.register_updated)
        else $error("hash fields set without k-mer");

endmodule

bind kmer_setsketch_update ksu_checker u_ksu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
